@@ rtl/iot_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt ownership table package
// Shared widths, request and status codes, controller states and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package iot_pkg;

	// Field widths of the request and response words.
	localparam int FUNC_W   = 2;
	localparam int IRQ_W    = 16;
	localparam int PART_W   = 8;
	localparam int CPU_W    = 10;
	localparam int STATUS_W = 2;

	// Default table sizes.
	localparam int NUM_IRQ_DEF = 1024;
	localparam int NUM_CPU_DEF = 256;

	// Request kinds.
	localparam logic [FUNC_W-1:0] FUNC_ASSIGN = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_REVOKE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

	// Response status codes.
	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_INVAL  = 2'd1,
		ST_RANGE  = 2'd2,
		ST_DENIED = 2'd3
	} iot_status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOKUP
	} iot_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;
		logic capture;
		logic commit;
	} iot_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
	} iot_sts_t;

endpackage

@@ rtl/iot_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt ownership table channels
// Valid/ready channels for the request word and the response word.
// ----------------------------------------------------------------------------
interface iot_req_if;
	logic                          valid;
	logic                          ready;
	logic [iot_pkg::FUNC_W-1:0]    func;
	logic [iot_pkg::IRQ_W-1:0]     irq_number;
	logic [iot_pkg::PART_W-1:0]    partition;
	logic [iot_pkg::CPU_W-1:0]     cpu_target;

	modport source (output valid, func, irq_number, partition, cpu_target, input ready);
	modport sink (input valid, func, irq_number, partition, cpu_target, output ready);
endinterface

interface iot_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [iot_pkg::STATUS_W-1:0]  status;

	modport source (output valid, status, input ready);
	modport sink (input valid, status, output ready);
endinterface

@@ rtl/iot_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt ownership table controller
// Sequences the clearing pass after reset and the lookup and commit of each
// request, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module iot_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output iot_pkg::iot_cmd_t cmd,
	input  iot_pkg::iot_sts_t sts
);

	iot_pkg::iot_state_t state_q;
	iot_pkg::iot_state_t state_d;
	logic                out_valid_q;
	logic                slot_free;

	// The response register can take a new word when empty or being emptied.
	assign slot_free = !out_valid_q || rsp_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			iot_pkg::S_CLEAR: begin
				if (sts.clear_last) state_d = iot_pkg::S_IDLE;
			end
			iot_pkg::S_IDLE: begin
				if (req_valid) state_d = iot_pkg::S_LOOKUP;
			end
			iot_pkg::S_LOOKUP: begin
				if (slot_free) state_d = iot_pkg::S_IDLE;
			end
			default: state_d = iot_pkg::S_CLEAR;
		endcase
	end

	// Outputs and datapath commands.
	always_comb begin
		req_ready      = 1'b0;
		cmd.clear_step = 1'b0;
		cmd.capture    = 1'b0;
		cmd.commit     = 1'b0;
		case (state_q)
			iot_pkg::S_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			iot_pkg::S_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			iot_pkg::S_LOOKUP: begin
				cmd.commit = slot_free;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iot_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Response valid flag: set by a commit, cleared when the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

@@ rtl/iot_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt ownership table datapath
// Holds the ownership memory, the captured request, the clearing counter and
// the decision logic that forms the status and the table update.
// ----------------------------------------------------------------------------
module iot_datapath #(
	parameter int NUM_IRQ = iot_pkg::NUM_IRQ_DEF,
	parameter int NUM_CPU = iot_pkg::NUM_CPU_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  iot_pkg::iot_cmd_t             cmd,
	output iot_pkg::iot_sts_t             sts,
	input  logic [iot_pkg::FUNC_W-1:0]    func,
	input  logic [iot_pkg::IRQ_W-1:0]     irq_number,
	input  logic [iot_pkg::PART_W-1:0]    partition,
	input  logic [iot_pkg::CPU_W-1:0]     cpu_target,
	output logic [iot_pkg::STATUS_W-1:0]  status
);

	localparam int IW = $clog2(NUM_IRQ);
	localparam int CW = (NUM_CPU > 1) ? $clog2(NUM_CPU) : 1;
	localparam int EW = iot_pkg::PART_W + CW;
	localparam logic [IW-1:0]             LAST_IDX  = IW'(NUM_IRQ - 1);
	localparam logic [iot_pkg::IRQ_W:0]   IRQ_LIMIT = (iot_pkg::IRQ_W + 1)'(NUM_IRQ);
	localparam logic [iot_pkg::CPU_W:0]   CPU_LIMIT = (iot_pkg::CPU_W + 1)'(NUM_CPU);

	// Ownership memory: owning partition above, target CPU below.
	logic [EW-1:0] mem [NUM_IRQ];

	logic [iot_pkg::FUNC_W-1:0]  func_q;
	logic [iot_pkg::IRQ_W-1:0]   line_q;
	logic [iot_pkg::PART_W-1:0]  part_q;
	logic [iot_pkg::CPU_W-1:0]   cpu_q;
	logic [EW-1:0]               rd_q;
	logic [IW-1:0]               clr_cnt_q;
	iot_pkg::iot_status_t        status_q;

	logic [IW-1:0]               rd_addr;
	logic [IW-1:0]               wr_addr;
	logic [EW-1:0]               wr_data;
	logic                        wr_en;
	logic [EW-1:0]               upd_data;
	logic                        upd_ok;
	iot_pkg::iot_status_t        status_d;
	logic [iot_pkg::PART_W-1:0]  holder;
	logic [CW-1:0]               holder_cpu;
	logic                        line_oor;
	logic                        cpu_oor;

	// Capture the request word on acceptance.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= func;
			line_q <= irq_number;
			part_q <= partition;
			cpu_q  <= cpu_target;
		end
	end

	// The read is issued with the accepted word, so the entry is registered and ready in the cycle after acceptance.
	assign rd_addr = cmd.capture ? irq_number[IW-1:0] : line_q[IW-1:0];

	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
	end

	// Clearing counter walks every entry once after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	assign sts.clear_last = (clr_cnt_q == LAST_IDX);

	// Decision on the captured request and the entry read for it.
	assign holder     = rd_q[EW-1:CW];
	assign holder_cpu = rd_q[CW-1:0];
	assign line_oor   = {1'b0, line_q} >= IRQ_LIMIT;
	assign cpu_oor    = {1'b0, cpu_q} >= CPU_LIMIT;

	always_comb begin
		status_d = iot_pkg::ST_OK;
		upd_ok   = 1'b0;
		upd_data = '0;
		if (!(func_q inside {iot_pkg::FUNC_ASSIGN, iot_pkg::FUNC_REVOKE,
				iot_pkg::FUNC_QUERY}) || line_q == '0 || part_q == '0) begin
			status_d = iot_pkg::ST_INVAL;
		end else if (line_oor) begin
			status_d = iot_pkg::ST_RANGE;
		end else begin
			case (func_q)
				iot_pkg::FUNC_ASSIGN: begin
					if (cpu_oor) begin
						status_d = iot_pkg::ST_RANGE;
					end else if (holder != '0 && holder != part_q) begin
						status_d = iot_pkg::ST_DENIED;
					end else if (holder == part_q && holder_cpu != cpu_q[CW-1:0]) begin
						status_d = iot_pkg::ST_DENIED;
					end else begin
						upd_ok   = 1'b1;
						upd_data = {part_q, cpu_q[CW-1:0]};
					end
				end
				iot_pkg::FUNC_REVOKE: begin
					if (holder != part_q) begin
						status_d = iot_pkg::ST_DENIED;
					end else begin
						upd_ok = 1'b1;
					end
				end
				default: begin
					if (holder != part_q) status_d = iot_pkg::ST_DENIED;
				end
			endcase
		end
	end

	// Memory write port: clearing pass or table update.
	assign wr_en   = cmd.clear_step || (cmd.commit && upd_ok);
	assign wr_addr = cmd.clear_step ? clr_cnt_q : line_q[IW-1:0];
	assign wr_data = cmd.clear_step ? '0 : upd_data;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Response status register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			status_q <= status_d;
		end
	end

	assign status = status_q;

endmodule

@@ rtl/irq_ownership_table_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt ownership table
// Keeps an owning partition and a target CPU for every interrupt line and
// answers assign, revoke and query requests with one status word each.
// ----------------------------------------------------------------------------
// After reset the block clears its table, one entry a cycle, with req.ready
// low. After that each request passes through the states S_IDLE, in which it
// is accepted and the read of its table entry is issued, and S_LOOKUP, which
// waits until the response register is free, then decides the status, writes
// the entry back if the request succeeds and loads the response register. A
// new request is accepted in the cycle after the response register is loaded,
// even while that word still waits, so the block takes no new request before
// the last one has been committed.
// ----------------------------------------------------------------------------
module irq_ownership_table_top #(
	parameter int NUM_IRQ = iot_pkg::NUM_IRQ_DEF,
	parameter int NUM_CPU = iot_pkg::NUM_CPU_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	iot_req_if.sink   req,
	iot_rsp_if.source rsp
);

	iot_pkg::iot_cmd_t cmd;
	iot_pkg::iot_sts_t sts;

	// Request sequencing and handshakes.
	iot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// Table and decision logic.
	iot_datapath #(
		.NUM_IRQ (NUM_IRQ),
		.NUM_CPU (NUM_CPU)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.func       (req.func),
		.irq_number (req.irq_number),
		.partition  (req.partition),
		.cpu_target (req.cpu_target),
		.status     (rsp.status)
	);

endmodule

@@ rtl/iot_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Interrupt ownership table checker
// Watches the ports of the top level for handshake and sequencing slips.
// ----------------------------------------------------------------------------
module iot_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic [iot_pkg::FUNC_W-1:0]    func,
	input logic [iot_pkg::IRQ_W-1:0]     irq_number,
	input logic [iot_pkg::PART_W-1:0]    partition,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic [iot_pkg::STATUS_W-1:0]  status
);

	logic req_acc;
	logic req_bad;

	assign req_acc = req_valid && req_ready;
	assign req_bad = (func != iot_pkg::FUNC_ASSIGN && func != iot_pkg::FUNC_REVOKE &&
			func != iot_pkg::FUNC_QUERY) || irq_number == '0 || partition == '0;

	// A waiting response word stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word withdrawn before it was taken");

	// A waiting response word keeps its status.
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(status))
		else $error("response status changed while stalled");

	// One request at a time: no acceptance right after an acceptance.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("request accepted while the previous one is in lookup");

	// A malformed request into an empty response slot answers invalid once its lookup commits.
	a_inval_answer: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc && req_bad && !rsp_valid |=> ##1
			(rsp_valid && status == iot_pkg::ST_INVAL))
		else $error("malformed request not answered as invalid");

endmodule

bind irq_ownership_table_top iot_checker u_iot_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.func       (req.func),
	.irq_number (req.irq_number),
	.partition  (req.partition),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.status     (rsp.status)
);
